[rtl/core/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and controller/datapath interface types for the
// buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MEM_ORDER_DEF = 10;

    // Item field widths
    localparam int OP_W   = 1;
    localparam int SIZE_W = 11;
    localparam int OFF_W  = 10;
    localparam int ORD_W  = 4;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;
    localparam logic [ST_W-1:0] ST_UNK  = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_KSTEP,
        CMD_SINIT,
        CMD_SREAD,
        CMD_SNEXTI,
        CMD_SNEXTJ,
        CMD_STAKE,
        CMD_SSPLIT,
        CMD_SFIN,
        CMD_FREAD,
        CMD_FSTART,
        CMD_MREAD,
        CMD_MKILL,
        CMD_MSELF,
        CMD_MSET,
        CMD_RBAD,
        CMD_RNONE,
        CMD_RUNK,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic            clr_done;
        logic [OP_W-1:0] op;
        logic            size_bad;
        logic            off_bad;
        logic            k_ok;
        logic            fm_bit;
        logic            at_valid;
        logic            i_last;
        logic            j_top;
        logic            k_top;
        logic            j_eq_k;
        logic            slot_free;
    } t_stat;

endpackage

[rtl/core/bba_datapath.sv]
// ----------------------------------------------------------------------------
// bba_datapath
// Free map and order table memories, search/merge registers and the
// result/output registers, driven one command per cycle.
// ----------------------------------------------------------------------------
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MEM_ORDER = MEM_ORDER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [OP_W-1:0]   i_op,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [OFF_W-1:0]  i_offin,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OFF_W-1:0]  o_off,
    output logic [ORD_W-1:0]  o_ord,
    output logic [ST_W-1:0]   o_st
);

    localparam int NAW   = MEM_ORDER + 1;
    localparam int NODES = (2 ** NAW) - 1;
    localparam int POOL  = 2 ** MEM_ORDER;
    localparam int OW    = $clog2(MEM_ORDER + 1);
    localparam int CW    = (MEM_ORDER + 1 > SIZE_W) ? MEM_ORDER + 1 : SIZE_W;
    localparam int XW    = (MEM_ORDER + 1 > OFF_W) ? MEM_ORDER + 1 : OFF_W;

    typedef logic [MEM_ORDER-1:0] t_off;
    typedef logic [NAW-1:0]       t_node;
    typedef logic [OW-1:0]        t_ord;

    // tree node of block (order, offset)
    function automatic t_node node_of(input t_ord j, input t_off off);
        t_node base;
        base = (t_node'(1) << (MEM_ORDER - int'(j))) - t_node'(1);
        return base + t_node'(off >> j);
    endfunction

    logic        r_fm [NODES];
    logic        r_fm_q;
    logic [OW:0] r_at [POOL];
    logic [OW:0] r_at_q;

    logic [NAW-1:0]    r_clr;
    logic              r_ovalid;
    logic [OP_W-1:0]   r_op;
    logic [SIZE_W-1:0] r_size;
    logic [OFF_W-1:0]  r_offin;
    t_ord              r_k;
    t_ord              r_j;
    t_off              r_i;
    t_off              r_off;
    logic [OFF_W-1:0]  r_res_off;
    logic [ORD_W-1:0]  r_res_ord;
    logic [ST_W-1:0]   r_res_st;
    logic [OFF_W-1:0]  r_o_off;
    logic [ORD_W-1:0]  r_o_ord;
    logic [ST_W-1:0]   r_o_st;

    logic  fm_we, fm_wd;
    t_node fm_wa, fm_ra;
    logic  at_we;
    t_off  at_wa;
    logic [OW:0] at_wd;

    t_off  off_found, bit_k, buddy, split_off;
    t_node snode;
    t_ord  jm1, ordc;

    assign off_found = t_off'(r_i << r_j);
    assign snode     = node_of(r_j, off_found);
    assign bit_k     = t_off'(1) << r_k;
    assign buddy     = r_off ^ bit_k;
    assign jm1       = r_j - t_ord'(1);
    assign split_off = r_off | (t_off'(1) << jm1);
    assign ordc      = (r_at_q[OW-1:0] > t_ord'(MEM_ORDER)) ? t_ord'(MEM_ORDER)
                                                           : r_at_q[OW-1:0];

    always_comb begin
        fm_we = 1'b0;
        fm_wa = '0;
        fm_wd = 1'b0;
        fm_ra = snode;
        at_we = 1'b0;
        at_wa = r_off;
        at_wd = '0;
        case (i_cmd)
            CMD_CLEAR: begin
                fm_we = ~&r_clr;
                fm_wa = r_clr;
                fm_wd = (r_clr == '0);
                at_we = ~r_clr[MEM_ORDER];
                at_wa = r_clr[MEM_ORDER-1:0];
            end
            CMD_STAKE: begin
                fm_we = 1'b1;
                fm_wa = snode;
            end
            CMD_SSPLIT: begin
                fm_we = 1'b1;
                fm_wa = node_of(jm1, split_off);
                fm_wd = 1'b1;
            end
            CMD_SFIN: begin
                at_we = 1'b1;
                at_wd = {1'b1, r_k};
            end
            CMD_FSTART: begin
                at_we = 1'b1;
                fm_we = 1'b1;
                fm_wa = node_of(ordc, r_off);
                fm_wd = 1'b1;
            end
            CMD_MREAD: fm_ra = node_of(r_k, buddy);
            CMD_MKILL: begin
                fm_we = 1'b1;
                fm_wa = node_of(r_k, buddy);
            end
            CMD_MSELF: begin
                fm_we = 1'b1;
                fm_wa = node_of(r_k, r_off);
            end
            CMD_MSET: begin
                fm_we = 1'b1;
                fm_wa = node_of(r_k, r_off);
                fm_wd = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_fm[fm_wa] <= fm_wd;
        end
        r_fm_q <= r_fm[fm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (at_we) begin
            r_at[at_wa] <= at_wd;
        end
        r_at_q <= r_at[r_off];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd == CMD_CLEAR && !(&r_clr)) begin
                r_clr <= r_clr + NAW'(1);
            end
            if (i_cmd == CMD_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_op    <= i_op;
                r_size  <= i_size;
                r_offin <= i_offin;
                r_k     <= '0;
                r_off   <= t_off'(i_offin);
            end
            CMD_KSTEP: r_k <= r_k + t_ord'(1);
            CMD_SINIT: begin
                r_j <= r_k;
                r_i <= '0;
            end
            CMD_SNEXTI: r_i <= r_i + t_off'(1);
            CMD_SNEXTJ: begin
                r_j <= r_j + t_ord'(1);
                r_i <= '0;
            end
            CMD_STAKE:  r_off <= off_found;
            CMD_SSPLIT: r_j   <= jm1;
            CMD_SFIN: begin
                r_res_off <= OFF_W'(r_off);
                r_res_ord <= ORD_W'(r_k);
                r_res_st  <= ST_OK;
            end
            CMD_FSTART: begin
                r_k       <= ordc;
                r_res_off <= r_offin;
                r_res_ord <= ORD_W'(ordc);
                r_res_st  <= ST_OK;
            end
            CMD_MSELF: begin
                r_off <= r_off & ~bit_k;
                r_k   <= r_k + t_ord'(1);
            end
            CMD_RBAD: begin
                r_res_off <= '0;
                r_res_ord <= '0;
                r_res_st  <= ST_BAD;
            end
            CMD_RNONE: begin
                r_res_off <= '0;
                r_res_ord <= '0;
                r_res_st  <= ST_NONE;
            end
            CMD_RUNK: begin
                r_res_off <= r_offin;
                r_res_ord <= '0;
                r_res_st  <= ST_UNK;
            end
            CMD_EMIT: begin
                r_o_off <= r_res_off;
                r_o_ord <= r_res_ord;
                r_o_st  <= r_res_st;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.clr_done  = &r_clr;
        o_stat.op        = r_op;
        o_stat.size_bad  = (r_size == '0) ||
                           (CW'(r_size) > (CW'(1) << MEM_ORDER));
        o_stat.off_bad   = XW'(r_offin) >= (XW'(1) << MEM_ORDER);
        o_stat.k_ok      = (CW'(1) << r_k) >= CW'(r_size);
        o_stat.fm_bit    = r_fm_q;
        o_stat.at_valid  = r_at_q[OW];
        o_stat.i_last    = r_i == ((t_off'(1) << (MEM_ORDER - int'(r_j))) - t_off'(1));
        o_stat.j_top     = r_j == t_ord'(MEM_ORDER);
        o_stat.k_top     = r_k == t_ord'(MEM_ORDER);
        o_stat.j_eq_k    = r_j == r_k;
        o_stat.slot_free = !r_ovalid || i_m_tready;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_off      = r_o_off;
    assign o_ord      = r_o_ord;
    assign o_st       = r_o_st;

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_EMIT |-> !r_ovalid || i_m_tready)
        else $error("result loaded over an untaken one");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_o_st == ST_BAD || r_o_st == ST_NONE) |->
            r_o_off == '0 && r_o_ord == '0)
        else $error("failed allocate carries a block");

    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_SSPLIT |-> r_j > r_k)
        else $error("split below the requested order");

endmodule

[rtl/core/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for clearing, order search, splitting and buddy merging.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DEC   = 13'b0000000000100,
        S_KSZ   = 13'b0000000001000,
        S_SRD   = 13'b0000000010000,
        S_SCHK  = 13'b0000000100000,
        S_SSPL  = 13'b0000001000000,
        S_FCHK  = 13'b0000010000000,
        S_MRD   = 13'b0000100000000,
        S_MCHK  = 13'b0001000000000,
        S_MSELF = 13'b0010000000000,
        S_MSET  = 13'b0100000000000,
        S_RES   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.op == OP_ALLOC) begin
                    if (i_stat.size_bad) begin
                        o_cmd   = CMD_RBAD;
                        n_state = S_RES;
                    end else begin
                        n_state = S_KSZ;
                    end
                end else if (i_stat.off_bad) begin
                    o_cmd   = CMD_RUNK;
                    n_state = S_RES;
                end else begin
                    o_cmd   = CMD_FREAD;
                    n_state = S_FCHK;
                end
            end
            S_KSZ: begin
                if (i_stat.k_ok) begin
                    o_cmd   = CMD_SINIT;
                    n_state = S_SRD;
                end else begin
                    o_cmd = CMD_KSTEP;
                end
            end
            S_SRD: begin
                o_cmd   = CMD_SREAD;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (i_stat.fm_bit) begin
                    o_cmd   = CMD_STAKE;
                    n_state = S_SSPL;
                end else if (!i_stat.i_last) begin
                    o_cmd   = CMD_SNEXTI;
                    n_state = S_SRD;
                end else if (!i_stat.j_top) begin
                    o_cmd   = CMD_SNEXTJ;
                    n_state = S_SRD;
                end else begin
                    o_cmd   = CMD_RNONE;
                    n_state = S_RES;
                end
            end
            S_SSPL: begin
                if (i_stat.j_eq_k) begin
                    o_cmd   = CMD_SFIN;
                    n_state = S_RES;
                end else begin
                    o_cmd = CMD_SSPLIT;
                end
            end
            S_FCHK: begin
                if (i_stat.at_valid) begin
                    o_cmd   = CMD_FSTART;
                    n_state = S_MRD;
                end else begin
                    o_cmd   = CMD_RUNK;
                    n_state = S_RES;
                end
            end
            S_MRD: begin
                if (i_stat.k_top) begin
                    n_state = S_RES;
                end else begin
                    o_cmd   = CMD_MREAD;
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_stat.fm_bit) begin
                    o_cmd   = CMD_MKILL;
                    n_state = S_MSELF;
                end else begin
                    n_state = S_RES;
                end
            end
            S_MSELF: begin
                o_cmd   = CMD_MSELF;
                n_state = S_MSET;
            end
            S_MSET: begin
                o_cmd   = CMD_MSET;
                n_state = S_MRD;
            end
            S_RES: begin
                if (i_stat.slot_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

[rtl/core/buddy_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator over a pool of 2^MEM_ORDER bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one request: tuser is the operation (allocate or
//   free), tdata carries the size and the offset to free. Master channel
//   returns one result per request: offset, order and status.
//   After reset a clearing pass sweeps both maps; no request is taken
//   meanwhile. Requests are handled one at a time; tready is high only
//   when idle, and the next request can be taken in the cycle after a
//   result is loaded. Allocate: the size order is found first, then
//   free-map nodes are scanned (smallest fitting order upwards, lowest
//   offset first), then the block is split down; the scan through the
//   single free-map read port dominates, at worst about 2^(MEM_ORDER+1)
//   nodes. Free: the order table is checked, then buddies are merged, up
//   to MEM_ORDER merges. Bad sizes are rejected at decode, unknown offsets
//   at decode or at the order-table check.
//   Results sit in an output register; a new request is taken while a
//   result waits, and the next result holds until the receiver takes it.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core
    import bba_pkg::*;
#(
    parameter int MEM_ORDER = MEM_ORDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // request_size[10:0], block_offset_in[20:11]
    input  logic [0:0]  i_s_tuser,  // operation[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // block_offset_out[9:0], block_order[13:10], status[15:14]
);

    t_cmd  cmd;
    t_stat stat;
    logic [OFF_W-1:0] out_off;
    logic [ORD_W-1:0] out_ord;
    logic [ST_W-1:0]  out_st;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bba_datapath #(
        .MEM_ORDER (MEM_ORDER)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_op       (i_s_tuser),
        .i_size     (i_s_tdata[SIZE_W-1:0]),
        .i_offin    (i_s_tdata[SIZE_W+OFF_W-1:SIZE_W]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_off      (out_off),
        .o_ord      (out_ord),
        .o_st       (out_st)
    );

    assign o_m_tdata = {out_st, out_ord, out_off};

endmodule
